// ===== design/chse_pkg.sv =====
// Shared constants and types for the cubic Hermite segment evaluator.
// No dependencies.
package chse_pkg;
   localparam int DW = 32;              // field width
   localparam int FB = 16;              // fraction bits
   localparam int SW = DW + 3;          // narrow signed terms of the first stage
   localparam int NW = 5 * DW + 4;      // exact numerator width
   localparam int QW = 3 * DW + FB;     // divisor width, 2^FB * D^3
   localparam int LW = DW;              // limb width of a wide operand
   localparam int NL = (NW + LW - 1) / LW;  // limbs per wide operand
   localparam int PW = LW + SW;         // limb partial product, narrow product

   typedef struct packed {
      logic signed [NW-1:0] num;
      logic [QW-1:0]        den;
      logic                 zero;
   } chse_frac_type;

   typedef struct packed {
      logic [DW-1:0] position;
      logic          saturated;
      logic          zero_duration;
   } chse_res_type;
endpackage

// ===== design/chse_poly.sv =====
// Limb multiplier and the numerator and divisor pipeline: nine register stages.
// Depends on chse_pkg.

// wide by narrow product, modulo 2^NW, two stages: limb products, then sum
module chse_mul import chse_pkg::*; (
   input  logic                 clock,
   input  logic                 adv,
   input  logic [NW-1:0]        a,
   input  logic signed [SW-1:0] b,
   output logic [NW-1:0]        p
);
   logic [NL*LW-1:0]     a_ext;
   logic signed [PW-1:0] pp_ff [0:NL-1];
   logic [NW-1:0]        p_in;
   logic [NW-1:0]        p_ff;

   assign a_ext = (NL*LW)'(a);

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NL; i++) begin
            pp_ff[i] <= PW'($signed({1'b0, a_ext[i*LW +: LW]})) * PW'(b);
         end
      end
   end

   always_comb begin
      p_in = '0;
      for (int i = 0; i < NL; i++) begin
         p_in = p_in + (NW'(pp_ff[i]) << (i * LW));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;
endmodule

module chse_poly import chse_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [DW-1:0]        elapsed,
   input  logic [DW-1:0]        duration,
   input  logic signed [DW-1:0] start_pos,
   input  logic signed [DW-1:0] start_vel,
   input  logic signed [DW-1:0] end_pos,
   input  logic signed [DW-1:0] end_vel,
   output logic                 out_valid,
   output chse_frac_type        out_frac
);
   logic [8:0] vld_ff;
   logic [7:0] zero_ff;

   // stage 1
   logic signed [SW-1:0] e1_ff, d1_ff, dm1_ff, a1_ff, b1_ff;
   logic signed [DW-1:0] x0_ff, x1_ff, v0_ff, v1_ff;
   logic signed [SW-1:0] e_in, d_in, dm_in, a_in, b_in;
   // stage 2: products of two narrow terms
   logic signed [PW-1:0] xa_in, xb_in, dd_in;
   logic signed [PW:0]   vd_in;
   logic signed [PW-1:0] xa2_ff, xb2_ff, dd2_ff;
   logic signed [PW:0]   vd2_ff;
   logic signed [SW-1:0] e2_ff, d2_ff, dm2_ff;
   // stages 3 to 8: wide products, two stages each
   logic signed [SW-1:0] e3_ff, dm3_ff, d3_ff, e4_ff, dm4_ff, d4_ff, d5_ff, d6_ff;
   logic [NW-1:0]        p4, q4, r4, ddd4, p6, q6, r6, r8;
   logic [3*DW-1:0]      ddd5_ff, ddd6_ff, ddd7_ff, ddd8_ff;
   logic [NW-1:0]        pos7_ff, pos8_ff;
   // stage 9
   chse_frac_type        frac_ff;

   always_comb begin
      e_in  = SW'($signed({1'b0, elapsed}));
      d_in  = SW'($signed({1'b0, duration}));
      dm_in = d_in - e_in;
      a_in  = d_in + (e_in <<< 1);
      b_in  = (d_in <<< 1) + d_in - (e_in <<< 1);

      xa_in = PW'(x0_ff) * PW'(a1_ff);
      xb_in = PW'(x1_ff) * PW'(b1_ff);
      dd_in = PW'(d1_ff) * PW'(d1_ff);
      // V0 (D-E) - V1 E
      vd_in = (PW+1)'(v0_ff) * (PW+1)'(dm1_ff) - (PW+1)'(v1_ff) * (PW+1)'(e1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[7:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_ff   <= e_in;
         d1_ff   <= d_in;
         dm1_ff  <= dm_in;
         a1_ff   <= a_in;
         b1_ff   <= b_in;
         x0_ff   <= start_pos;
         x1_ff   <= end_pos;
         v0_ff   <= start_vel;
         v1_ff   <= end_vel;
         zero_ff <= {zero_ff[6:0], (duration == '0)};

         xa2_ff <= xa_in;
         xb2_ff <= xb_in;
         vd2_ff <= vd_in;
         dd2_ff <= dd_in;
         e2_ff  <= e1_ff;
         d2_ff  <= d1_ff;
         dm2_ff <= dm1_ff;

         e3_ff  <= e2_ff;
         dm3_ff <= dm2_ff;
         d3_ff  <= d2_ff;
         e4_ff  <= e3_ff;
         dm4_ff <= dm3_ff;
         d4_ff  <= d3_ff;
         d5_ff  <= d4_ff;
         d6_ff  <= d5_ff;

         ddd5_ff <= ddd4[3*DW-1:0];
         ddd6_ff <= ddd5_ff;
         ddd7_ff <= ddd6_ff;
         ddd8_ff <= ddd7_ff;

         pos7_ff <= p6 + q6;
         pos8_ff <= pos7_ff;

         frac_ff.num  <= (pos8_ff << FB) + r8;
         frac_ff.den  <= {ddd8_ff, {FB{1'b0}}};
         frac_ff.zero <= zero_ff[7];
      end
   end

   // X0 (D+2E) (D-E)^2, X1 (3D-2E) E^2, (V0 (D-E) - V1 E) (D-E) E D, D^3
   chse_mul u_p1 (.clock(clock), .adv(adv), .a(NW'(xa2_ff)), .b(dm2_ff), .p(p4));
   chse_mul u_q1 (.clock(clock), .adv(adv), .a(NW'(xb2_ff)), .b(e2_ff),  .p(q4));
   chse_mul u_r1 (.clock(clock), .adv(adv), .a(NW'(vd2_ff)), .b(dm2_ff), .p(r4));
   chse_mul u_dd (.clock(clock), .adv(adv), .a(NW'(dd2_ff)), .b(d2_ff),  .p(ddd4));

   chse_mul u_p2 (.clock(clock), .adv(adv), .a(p4), .b(dm4_ff), .p(p6));
   chse_mul u_q2 (.clock(clock), .adv(adv), .a(q4), .b(e4_ff),  .p(q6));
   chse_mul u_r2 (.clock(clock), .adv(adv), .a(r4), .b(e4_ff),  .p(r6));

   chse_mul u_r3 (.clock(clock), .adv(adv), .a(r6), .b(d6_ff),  .p(r8));

   assign out_valid = vld_ff[8];
   assign out_frac  = frac_ff;
endmodule

// ===== design/chse_div.sv =====
// Restoring divider, one quotient bit per stage, with rounding toward zero
// and saturation. Depends on chse_pkg.
module chse_div import chse_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  chse_frac_type in_frac,
   output logic          out_valid,
   output chse_res_type  out_res
);
   logic [NW-1:0] rem_ff [0:DW];
   logic [QW-1:0] den_ff [0:DW];
   logic [DW-1:0] q_ff   [0:DW];
   logic          neg_ff [0:DW];
   logic          sat_ff [0:DW];
   logic          z_ff   [0:DW];
   logic [DW:0]   vld_ff;

   logic          neg_in;
   logic [NW-1:0] mag_in;

   always_comb begin
      neg_in = in_frac.num[NW-1];
      mag_in = neg_in ? NW'(-in_frac.num) : NW'(in_frac.num);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= mag_in;
         den_ff[0] <= in_frac.den;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg_in;
         sat_ff[0] <= (mag_in >= NW'({in_frac.den, {DW{1'b0}}}));
         z_ff[0]   <= in_frac.zero;
      end
   end

   for (genvar k = 1; k <= DW; k++) begin : g_bit
      localparam int B = DW - k;
      logic [NW-1:0] sh;
      logic          take;
      always_comb begin
         sh   = NW'(den_ff[k-1]) << B;
         take = (rem_ff[k-1] >= sh);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= take ? rem_ff[k-1] - sh : rem_ff[k-1];
            q_ff[k]   <= q_ff[k-1] | (DW'(take) << B);
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
            z_ff[k]   <= z_ff[k-1];
         end
      end
   end

   logic          sat;
   logic [DW-1:0] q;
   logic          neg;

   always_comb begin
      q   = q_ff[DW];
      neg = neg_ff[DW];
      sat = sat_ff[DW] | (!neg && q[DW-1]) | (neg && q[DW-1] && (q[DW-2:0] != '0));
      out_res.zero_duration = z_ff[DW];
      if (z_ff[DW]) begin
         out_res.position  = '0;
         out_res.saturated = 1'b0;
      end else if (sat) begin
         out_res.position  = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
         out_res.saturated = 1'b1;
      end else begin
         out_res.position  = neg ? -q : q;
         out_res.saturated = 1'b0;
      end
   end

   assign out_valid = vld_ff[DW];
endmodule

// ===== design/cubic_hermite_segment_eval_unit.sv =====
// Cubic Hermite segment evaluator, top level. Uses chse_poly and chse_div.
// Pipeline from item acceptance to rsp_tvalid: 9 product stages,
// 1 sign stage, 32 quotient-bit stages, 1 output register.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits at the output. Reset clears the valid bits only.
module cubic_hermite_segment_eval_unit import chse_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   // elapsed, duration, start_pos, start_vel, end_pos, end_vel
   input  logic [6*DW-1:0] req_tdata,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   // position
   output logic [DW-1:0]   rsp_tdata,
   // saturated, zero_duration
   output logic [1:0]      rsp_tuser
);
   logic          adv;
   logic          poly_valid;
   chse_frac_type poly_frac;
   logic          div_valid;
   chse_res_type  div_res;
   logic          rsp_valid_ff;
   chse_res_type  rsp_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   chse_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .elapsed   (req_tdata[DW-1:0]),
      .duration  (req_tdata[2*DW-1:DW]),
      .start_pos (req_tdata[3*DW-1:2*DW]),
      .start_vel (req_tdata[4*DW-1:3*DW]),
      .end_pos   (req_tdata[5*DW-1:4*DW]),
      .end_vel   (req_tdata[6*DW-1:5*DW]),
      .out_valid (poly_valid),
      .out_frac  (poly_frac)
   );

   chse_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (poly_valid),
      .in_frac   (poly_frac),
      .out_valid (div_valid),
      .out_res   (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= div_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.position;
   assign rsp_tuser  = {rsp_ff.zero_duration, rsp_ff.saturated};
endmodule
